[design/deq_pkg.sv]
// Shared types, codes and widths for the double-ended queue.
package deq_pkg;

  localparam int DEF_CAPACITY  = 256;
  localparam int DEF_WORD_BITS = 32;

  localparam int MODE_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int READ_W   = 32;
  localparam int STATUS_W = 2;
  localparam int FILL_W   = 9;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_PEEK_FRONT = 3'd4,
    MODE_PEEK_BACK  = 3'd5
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic execute;
    logic load;
  } cmd_t;

endpackage

[design/deq_ctrl.sv]
// Controller state machine of the double-ended queue.
module deq_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output deq_pkg::cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_LOAD = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  // The output register can take a new result when empty or being emptied.
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d       = state_q;
    cmd_o.capture = 1'b0;
    cmd_o.execute = 1'b0;
    cmd_o.load    = 1'b0;
    in_stall_o    = 1'b1;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.execute = 1'b1;
        state_d       = S_LOAD;
      end
      S_LOAD: begin
        if (out_free) begin
          cmd_o.load = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[design/deq_dpath.sv]
// Datapath of the double-ended queue: ring store, pointers, count and result register.
module deq_dpath #(
  parameter int CAPACITY  = deq_pkg::DEF_CAPACITY,
  parameter int WORD_BITS = deq_pkg::DEF_WORD_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  deq_pkg::cmd_t                 cmd_i,
  input  logic [deq_pkg::MODE_W-1:0]    mode_i,
  input  logic [deq_pkg::VALUE_W-1:0]   value_i,
  output logic [deq_pkg::READ_W-1:0]    read_value_o,
  output logic [deq_pkg::STATUS_W-1:0]  status_o,
  output logic [deq_pkg::FILL_W-1:0]    fill_count_o
);

  localparam int PTR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(CAPACITY - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [PTR_W-1:0] wrap_dec(input logic [PTR_W-1:0] p);
    return (p == '0) ? PTR_W'(CAPACITY - 1) : p - PTR_W'(1);
  endfunction

  logic [deq_pkg::MODE_W-1:0]  mode_q;
  logic [deq_pkg::VALUE_W-1:0] value_q;

  logic [PTR_W-1:0] front_q, front_d;
  logic [PTR_W-1:0] back_q, back_d;
  logic [CNT_W-1:0] count_q, count_d;

  logic [WORD_BITS-1:0] ring_q [CAPACITY];
  logic [WORD_BITS-1:0] rd_word_q;
  logic                 mem_we, mem_re;
  logic [PTR_W-1:0]     mem_waddr, mem_raddr;
  logic [WORD_BITS-1:0] mem_wdata;

  deq_pkg::status_e res_status_q, res_status_d;
  logic             res_read_q, res_read_d;

  logic [deq_pkg::READ_W-1:0]   read_value_q;
  logic [deq_pkg::STATUS_W-1:0] status_q;
  logic [deq_pkg::FILL_W-1:0]   fill_q;

  logic [63:0] value_ext;
  logic [63:0] rd_ext;
  logic [31:0] count_ext;
  logic        full, empty;

  assign value_ext = 64'(value_q);
  assign mem_wdata = value_ext[WORD_BITS-1:0];
  assign rd_ext    = 64'(rd_word_q);
  assign count_ext = 32'(count_q);
  assign full      = (count_q == CNT_W'(CAPACITY));
  assign empty     = (count_q == '0);

  always_comb begin
    front_d      = front_q;
    back_d       = back_q;
    count_d      = count_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_waddr    = back_q;
    mem_raddr    = front_q;
    res_status_d = res_status_q;
    res_read_d   = res_read_q;
    if (cmd_i.execute) begin
      res_status_d = deq_pkg::STATUS_OK;
      res_read_d   = 1'b0;
      case (mode_q)
        deq_pkg::MODE_PUSH_FRONT: begin
          if (full) begin
            res_status_d = deq_pkg::STATUS_FULL;
          end else begin
            front_d   = wrap_dec(front_q);
            mem_we    = 1'b1;
            mem_waddr = wrap_dec(front_q);
            count_d   = count_q + CNT_W'(1);
          end
        end
        deq_pkg::MODE_PUSH_BACK: begin
          if (full) begin
            res_status_d = deq_pkg::STATUS_FULL;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = back_q;
            back_d    = wrap_inc(back_q);
            count_d   = count_q + CNT_W'(1);
          end
        end
        deq_pkg::MODE_POP_FRONT, deq_pkg::MODE_PEEK_FRONT: begin
          if (empty) begin
            res_status_d = deq_pkg::STATUS_EMPTY;
          end else begin
            mem_re     = 1'b1;
            mem_raddr  = front_q;
            res_read_d = 1'b1;
            if (mode_q == deq_pkg::MODE_POP_FRONT) begin
              front_d = wrap_inc(front_q);
              count_d = count_q - CNT_W'(1);
            end
          end
        end
        deq_pkg::MODE_POP_BACK, deq_pkg::MODE_PEEK_BACK: begin
          if (empty) begin
            res_status_d = deq_pkg::STATUS_EMPTY;
          end else begin
            mem_re     = 1'b1;
            mem_raddr  = wrap_dec(back_q);
            res_read_d = 1'b1;
            if (mode_q == deq_pkg::MODE_POP_BACK) begin
              back_d  = wrap_dec(back_q);
              count_d = count_q - CNT_W'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q      <= '0;
      back_q       <= '0;
      count_q      <= '0;
      res_status_q <= deq_pkg::STATUS_OK;
      res_read_q   <= 1'b0;
    end else begin
      front_q      <= front_d;
      back_q       <= back_d;
      count_q      <= count_d;
      res_status_q <= res_status_d;
      res_read_q   <= res_read_d;
    end
  end

  // Ring store with one write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_word_q <= ring_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q  <= mode_i;
      value_q <= value_i;
    end
    if (cmd_i.load) begin
      read_value_q <= res_read_q ? rd_ext[deq_pkg::READ_W-1:0] : '0;
      status_q     <= res_status_q;
      fill_q       <= count_ext[deq_pkg::FILL_W-1:0];
    end
  end

  assign read_value_o = read_value_q;
  assign status_o     = status_q;
  assign fill_count_o = fill_q;

endmodule

[design/double_ended_queue_core.sv]
// Top level of the double-ended queue: controller, datapath and checks.
//
//   Channel  Direction  Handshake                  Payload
//   input    in         in_valid_i / in_stall_o    mode_i, value_i
//   output   out        out_valid_o / out_stall_i  read_value_o, status_o, fill_count_o
//
// Each transaction passes through capture, execute and result load, since the
// ring store's registered read port gives its word only in the cycle after the address.
// Reset clears the pointers, the element count and the control state at once; the
// ring store needs no clearing pass, since only written entries are ever read.
// A new input transaction is taken while an earlier result waits under out_stall_i;
// a finished result holds in the datapath, input stalled, until the output is free.
module double_ended_queue_core #(
  parameter int CAPACITY  = deq_pkg::DEF_CAPACITY,
  parameter int WORD_BITS = deq_pkg::DEF_WORD_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [deq_pkg::MODE_W-1:0]    mode_i,
  input  logic [deq_pkg::VALUE_W-1:0]   value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [deq_pkg::READ_W-1:0]    read_value_o,
  output logic [deq_pkg::STATUS_W-1:0]  status_o,
  output logic [deq_pkg::FILL_W-1:0]    fill_count_o
);

  deq_pkg::cmd_t cmd;

  // The controller sequences each transaction and owns the output valid flag.
  deq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // The datapath holds the ring, both pointers, the count and the result payload.
  deq_dpath #(
    .CAPACITY  (CAPACITY),
    .WORD_BITS (WORD_BITS)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .mode_i       (mode_i),
    .value_i      (value_i),
    .read_value_o (read_value_o),
    .status_o     (status_o),
    .fill_count_o (fill_count_o)
  );

`ifndef SYNTHESIS
  // An accepted transaction keeps the input side stalled while it executes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after an accepted transaction");

  // A dropped push is only reported when the queue holds its full capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == deq_pkg::STATUS_FULL) |->
      (fill_count_o == deq_pkg::FILL_W'(CAPACITY) && read_value_o == '0))
    else $error("full status with a wrong count or a nonzero word");

  // An empty report always comes with a zero count and a zero word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == deq_pkg::STATUS_EMPTY) |->
      (fill_count_o == '0 && read_value_o == '0))
    else $error("empty status with a nonzero count or word");

  // A result only appears after the datapath has worked on a transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd.load))
    else $error("result shown without a load");
`endif

endmodule
